// ===== rtl/aiff_pkg.sv =====
// ----------------------------------------------------------------------------
// aiff_pkg
// Shared constants for the AIFF/AIFC stream parser: tags, codes, bias.
// ----------------------------------------------------------------------------
package aiff_pkg;

    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_AIFC = 32'h41494643;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;
    localparam logic [31:0] TAG_FL32 = 32'h666C3332;
    localparam logic [31:0] TAG_FL64 = 32'h666C3634;

    localparam int          EXT_BIAS     = 16383;
    localparam int          MANT_POINT   = 63;
    localparam logic [14:0] EXP_UNITY    = 15'(EXT_BIAS + MANT_POINT);

    localparam logic [1:0] FUNC_DATA    = 2'd0;
    localparam logic [1:0] FUNC_EOS     = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] FMT_UNKNOWN = 3'd0;
    localparam logic [2:0] FMT_S8      = 3'd1;
    localparam logic [2:0] FMT_S16     = 3'd2;
    localparam logic [2:0] FMT_S24     = 3'd3;
    localparam logic [2:0] FMT_S32     = 3'd4;
    localparam logic [2:0] FMT_F32     = 3'd5;
    localparam logic [2:0] FMT_F64     = 3'd6;

    localparam logic [2:0] ERR_NO_FORM    = 3'd0;
    localparam logic [2:0] ERR_FORM_TYPE  = 3'd1;
    localparam logic [2:0] ERR_MISSING    = 3'd2;
    localparam logic [2:0] ERR_SSND_FIRST = 3'd3;
    localparam logic [2:0] ERR_DEPTH      = 3'd4;
    localparam logic [2:0] ERR_SHORT      = 3'd5;

endpackage

// ===== rtl/aiff_rate_conv.sv =====
// ----------------------------------------------------------------------------
// aiff_rate_conv
// 80-bit extended to int32 conversion: truncate toward zero, saturate.
// ----------------------------------------------------------------------------
module aiff_rate_conv
(
    input  logic [15:0] sign_exp,
    input  logic [63:0] mant,
    output logic [31:0] rate
);

    localparam logic [32:0] CAP = 33'h1_0000_0000 >> 1;

    logic [14:0] e;
    logic [14:0] sh;
    logic [14:0] rs;
    logic [63:0] lim;
    logic [63:0] shl;
    logic [63:0] shr;
    logic [32:0] mag;
    logic [31:0] neg;

    always_comb
    begin
        e   = sign_exp[14:0];
        sh  = e - aiff_pkg::EXP_UNITY;
        rs  = aiff_pkg::EXP_UNITY - e;
        lim = 64'h8000_0000 >> sh[4:0];
        shl = mant << sh[4:0];
        shr = mant >> rs[5:0];
        if (mant == 64'd0)
        begin
            mag = 33'd0;
        end
        else if (e >= aiff_pkg::EXP_UNITY)
        begin
            if (sh >= 15'd32 || mant > lim)
                mag = CAP;
            else
                mag = shl[32:0];
        end
        else
        begin
            if (rs >= 15'd64)
                mag = 33'd0;
            else if (shr > 64'(CAP))
                mag = CAP;
            else
                mag = shr[32:0];
        end
        neg = 32'd0 - mag[31:0];
        if (sign_exp[15])
            rate = neg;
        else if (mag > 33'h0_7FFF_FFFF)
            rate = 32'h7FFF_FFFF;
        else
            rate = mag[31:0];
    end

endmodule

// ===== rtl/aiff_stream_parser.sv =====
// ----------------------------------------------------------------------------
// aiff_stream_parser
// Byte-wide AIFF/AIFC parser: header info, then big-endian sample words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per handshake, func selects a
// file byte in data_byte, end of stream, or restart. Output channel
// (out_valid/out_ready): header, sample or error results, at most one per
// input word; most input words give none.
// Throughput: one input word per cycle while in_ready is high. A result is
// registered on the output in the cycle after the input word that causes it.
// The output register parts the channels: in_ready stays high while the
// result register is empty or is being taken; a stalled receiver holds
// in_ready low only while a result waits.
// The sample rate is converted in the cycle after the mantissa completes;
// the header result comes many bytes later, so it always sees the result.
// The channels*frames product is registered each cycle from kept values.
// Reset or a restart word returns the parser to waiting for the FORM tag.
// After an error, the final sample or a header with no samples, words are dropped until restart.
// ----------------------------------------------------------------------------
module aiff_stream_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [63:0] sample_word,
    output logic        last_sample,
    output logic [15:0] channel_count,
    output logic [31:0] frame_count,
    output logic [15:0] bit_depth,
    output logic signed [31:0] sample_rate_hz,
    output logic [2:0]  sample_format,
    output logic [2:0]  error_code
);

    typedef enum logic [4:0] {
        PH_FORM  = 5'd0,  PH_FSIZE = 5'd1,  PH_FTYPE = 5'd2,  PH_CID   = 5'd3,
        PH_CSIZE = 5'd4,  PH_SKIP  = 5'd5,  PH_CH    = 5'd6,  PH_FR    = 5'd7,
        PH_BD    = 5'd8,  PH_EXP   = 5'd9,  PH_MANT  = 5'd10, PH_CTYPE = 5'd11,
        PH_SOFF  = 5'd12, PH_SBLK  = 5'd13, PH_SSKIP = 5'd14, PH_SAMP  = 5'd15,
        PH_DONE  = 5'd16, PH_HALT  = 5'd17
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] tag_reg, tag_next;
    logic [32:0] skip_reg, skip_next;
    logic        aifc_reg, aifc_next;
    logic        comm_reg, comm_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] fr_reg, fr_next;
    logic [15:0] dep_reg, dep_next;
    logic [2:0]  fmt_reg, fmt_next;
    logic [15:0] exp_reg, exp_next;
    logic [31:0] rate_reg;
    logic [47:0] samp_reg, samp_next;
    logic [47:0] prod_reg;
    logic [63:0] mant_reg;
    logic        conv_pend_reg, conv_pend_next;
    logic [31:0] conv_rate;

    logic        res_valid;
    logic [1:0]  res_kind;
    logic [63:0] res_word;
    logic        res_last;
    logic        res_hdr;
    logic [2:0]  res_err;

    logic        accept;
    logic [63:0] acc_shift;
    logic [3:0]  idx_inc;
    logic [12:0] dep_bytes;
    logic [3:0]  len;
    logic [32:0] size;
    logic [32:0] total;
    logic [32:0] need;
    logic [32:0] skip_dec;
    logic [2:0]  fin_fmt;
    logic [15:0] fin_dep;
    logic [47:0] samp_dec;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [63:0] word_reg;
    logic        last_reg;
    logic [15:0] och_reg;
    logic [31:0] ofr_reg;
    logic [15:0] odep_reg;
    logic [31:0] orate_reg;
    logic [2:0]  ofmt_reg;
    logic [2:0]  oerr_reg;

    aiff_rate_conv u_rate
    (
        .sign_exp (exp_reg),
        .mant     (mant_reg),
        .rate     (conv_rate)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        tag_next       = tag_reg;
        skip_next      = skip_reg;
        aifc_next      = aifc_reg;
        comm_next      = comm_reg;
        ch_next        = ch_reg;
        fr_next        = fr_reg;
        dep_next       = dep_reg;
        fmt_next       = fmt_reg;
        exp_next       = exp_reg;
        samp_next      = samp_reg;
        conv_pend_next = 1'b0;
        res_valid      = 1'b0;
        res_kind       = aiff_pkg::KIND_HEADER;
        res_word       = 64'd0;
        res_last       = 1'b0;
        res_hdr        = 1'b0;
        res_err        = aiff_pkg::ERR_NO_FORM;

        acc_shift = {acc_reg[55:0], data_byte};
        idx_inc   = idx_reg + 4'd1;
        dep_bytes = dep_reg[15:3];
        case (phase_reg)
            PH_FORM, PH_FSIZE, PH_FTYPE, PH_CID, PH_CSIZE, PH_FR,
            PH_CTYPE, PH_SOFF, PH_SBLK: len = 4'd4;
            PH_CH, PH_BD, PH_EXP:       len = 4'd2;
            PH_MANT:                    len = 4'd8;
            PH_SAMP:                    len = (dep_bytes == 13'd0 || dep_bytes > 13'd8)
                                              ? 4'd1 : dep_bytes[3:0];
            default:                    len = 4'd1;
        endcase
        size     = {1'b0, acc_shift[31:0]};
        total    = size + {32'd0, size[0]};
        need     = aifc_reg ? 33'd22 : 33'd18;
        skip_dec = skip_reg - 33'd1;
        samp_dec = samp_reg - 48'd1;

        fin_fmt = aiff_pkg::FMT_UNKNOWN;
        fin_dep = dep_reg;
        if (aifc_reg && acc_shift[31:0] == aiff_pkg::TAG_FL32)
        begin
            fin_fmt = aiff_pkg::FMT_F32;
            fin_dep = 16'd32;
        end
        else if (aifc_reg && acc_shift[31:0] == aiff_pkg::TAG_FL64)
        begin
            fin_fmt = aiff_pkg::FMT_F64;
            fin_dep = 16'd64;
        end
        else
        begin
            case (dep_reg)
                16'd8:   fin_fmt = aiff_pkg::FMT_S8;
                16'd16:  fin_fmt = aiff_pkg::FMT_S16;
                16'd24:  fin_fmt = aiff_pkg::FMT_S24;
                16'd32:  fin_fmt = aiff_pkg::FMT_S32;
                16'd64:  fin_fmt = aiff_pkg::FMT_F64;
                default: fin_fmt = aiff_pkg::FMT_UNKNOWN;
            endcase
        end

        if (accept && func == aiff_pkg::FUNC_RESTART)
        begin
            phase_next = PH_FORM;
            idx_next   = 4'd0;
            acc_next   = 64'd0;
            tag_next   = 32'd0;
            skip_next  = 33'd0;
            aifc_next  = 1'b0;
            comm_next  = 1'b0;
            ch_next    = 16'd0;
            fr_next    = 32'd0;
            dep_next   = 16'd0;
            fmt_next   = aiff_pkg::FMT_UNKNOWN;
            exp_next   = 16'd0;
            samp_next  = 48'd0;
        end
        else if (accept && func == aiff_pkg::FUNC_EOS
                 && phase_reg != PH_DONE && phase_reg != PH_HALT)
        begin
            res_valid  = 1'b1;
            res_kind   = aiff_pkg::KIND_ERROR;
            phase_next = PH_HALT;
            if (phase_reg == PH_FORM)
                res_err = aiff_pkg::ERR_NO_FORM;
            else if (phase_reg <= PH_FTYPE)
                res_err = aiff_pkg::ERR_FORM_TYPE;
            else if (phase_reg <= PH_CTYPE)
                res_err = aiff_pkg::ERR_MISSING;
            else
                res_err = aiff_pkg::ERR_SHORT;
        end
        else if (accept && func == aiff_pkg::FUNC_DATA
                 && phase_reg != PH_DONE && phase_reg != PH_HALT)
        begin
            if (phase_reg == PH_SKIP)
            begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0)
                    phase_next = PH_CID;
            end
            else if (phase_reg == PH_SSKIP)
            begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0)
                begin
                    res_valid  = 1'b1;
                    res_hdr    = 1'b1;
                    samp_next  = prod_reg;
                    phase_next = (prod_reg == 48'd0) ? PH_DONE : PH_SAMP;
                end
            end
            else if (idx_inc < len)
            begin
                acc_next = acc_shift;
                idx_next = idx_inc;
            end
            else
            begin
                acc_next = 64'd0;
                idx_next = 4'd0;
                case (phase_reg)
                    PH_FORM:
                    begin
                        if (acc_shift[31:0] != aiff_pkg::TAG_FORM)
                        begin
                            res_valid  = 1'b1;
                            res_kind   = aiff_pkg::KIND_ERROR;
                            res_err    = aiff_pkg::ERR_NO_FORM;
                            phase_next = PH_HALT;
                        end
                        else
                            phase_next = PH_FSIZE;
                    end
                    PH_FSIZE: phase_next = PH_FTYPE;
                    PH_FTYPE:
                    begin
                        if (acc_shift[31:0] == aiff_pkg::TAG_AIFF)
                        begin
                            aifc_next  = 1'b0;
                            phase_next = PH_CID;
                        end
                        else if (acc_shift[31:0] == aiff_pkg::TAG_AIFC)
                        begin
                            aifc_next  = 1'b1;
                            phase_next = PH_CID;
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            res_kind   = aiff_pkg::KIND_ERROR;
                            res_err    = aiff_pkg::ERR_FORM_TYPE;
                            phase_next = PH_HALT;
                        end
                    end
                    PH_CID:
                    begin
                        tag_next   = acc_shift[31:0];
                        phase_next = PH_CSIZE;
                    end
                    PH_CSIZE:
                    begin
                        if (tag_reg == aiff_pkg::TAG_COMM)
                        begin
                            if (size < need)
                            begin
                                res_valid  = 1'b1;
                                res_kind   = aiff_pkg::KIND_ERROR;
                                res_err    = aiff_pkg::ERR_SHORT;
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                skip_next  = total - need;
                                phase_next = PH_CH;
                            end
                        end
                        else if (tag_reg == aiff_pkg::TAG_SSND)
                        begin
                            res_valid  = 1'b1;
                            res_kind   = aiff_pkg::KIND_ERROR;
                            phase_next = PH_HALT;
                            if (!comm_reg)
                                res_err = aiff_pkg::ERR_SSND_FIRST;
                            else if (size < 33'd8)
                                res_err = aiff_pkg::ERR_SHORT;
                            else
                            begin
                                res_valid  = 1'b0;
                                phase_next = PH_SOFF;
                            end
                        end
                        else
                        begin
                            skip_next  = total;
                            phase_next = (total == 33'd0) ? PH_CID : PH_SKIP;
                        end
                    end
                    PH_CH:
                    begin
                        ch_next    = acc_shift[15:0];
                        phase_next = PH_FR;
                    end
                    PH_FR:
                    begin
                        fr_next    = acc_shift[31:0];
                        phase_next = PH_BD;
                    end
                    PH_BD:
                    begin
                        dep_next   = acc_shift[15:0];
                        phase_next = PH_EXP;
                    end
                    PH_EXP:
                    begin
                        exp_next   = acc_shift[15:0];
                        phase_next = PH_MANT;
                    end
                    PH_MANT, PH_CTYPE:
                    begin
                        conv_pend_next = (phase_reg == PH_MANT);
                        if (phase_reg == PH_MANT && aifc_reg)
                            phase_next = PH_CTYPE;
                        else
                        begin
                            if (phase_reg == PH_CTYPE)
                                dep_next = fin_dep;
                            fmt_next = (phase_reg == PH_CTYPE) ? fin_fmt
                                       : (dep_reg == 16'd8)  ? aiff_pkg::FMT_S8
                                       : (dep_reg == 16'd16) ? aiff_pkg::FMT_S16
                                       : (dep_reg == 16'd24) ? aiff_pkg::FMT_S24
                                       : (dep_reg == 16'd32) ? aiff_pkg::FMT_S32
                                       : (dep_reg == 16'd64) ? aiff_pkg::FMT_F64
                                       : aiff_pkg::FMT_UNKNOWN;
                            if (fmt_next == aiff_pkg::FMT_UNKNOWN)
                            begin
                                res_valid  = 1'b1;
                                res_kind   = aiff_pkg::KIND_ERROR;
                                res_err    = aiff_pkg::ERR_DEPTH;
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                comm_next  = 1'b1;
                                phase_next = (skip_reg == 33'd0) ? PH_CID : PH_SKIP;
                            end
                        end
                    end
                    PH_SOFF:
                    begin
                        skip_next  = {1'b0, acc_shift[31:0]};
                        phase_next = PH_SBLK;
                    end
                    PH_SBLK:
                    begin
                        if (skip_reg == 33'd0)
                        begin
                            res_valid  = 1'b1;
                            res_hdr    = 1'b1;
                            samp_next  = prod_reg;
                            phase_next = (prod_reg == 48'd0) ? PH_DONE : PH_SAMP;
                        end
                        else
                            phase_next = PH_SSKIP;
                    end
                    PH_SAMP:
                    begin
                        samp_next = samp_dec;
                        res_valid = 1'b1;
                        res_kind  = aiff_pkg::KIND_SAMPLE;
                        res_word  = acc_shift;
                        res_last  = (samp_dec == 48'd0);
                        if (samp_dec == 48'd0)
                            phase_next = PH_DONE;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FORM;
            idx_reg       <= 4'd0;
            acc_reg       <= 64'd0;
            tag_reg       <= 32'd0;
            skip_reg      <= 33'd0;
            aifc_reg      <= 1'b0;
            comm_reg      <= 1'b0;
            ch_reg        <= 16'd0;
            fr_reg        <= 32'd0;
            dep_reg       <= 16'd0;
            fmt_reg       <= aiff_pkg::FMT_UNKNOWN;
            exp_reg       <= 16'd0;
            rate_reg      <= 32'd0;
            samp_reg      <= 48'd0;
            prod_reg      <= 48'd0;
            mant_reg      <= 64'd0;
            conv_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= aiff_pkg::KIND_HEADER;
            word_reg      <= 64'd0;
            last_reg      <= 1'b0;
            och_reg       <= 16'd0;
            ofr_reg       <= 32'd0;
            odep_reg      <= 16'd0;
            orate_reg     <= 32'd0;
            ofmt_reg      <= aiff_pkg::FMT_UNKNOWN;
            oerr_reg      <= aiff_pkg::ERR_NO_FORM;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            tag_reg       <= tag_next;
            skip_reg      <= skip_next;
            aifc_reg      <= aifc_next;
            comm_reg      <= comm_next;
            ch_reg        <= ch_next;
            fr_reg        <= fr_next;
            dep_reg       <= dep_next;
            fmt_reg       <= fmt_next;
            exp_reg       <= exp_next;
            samp_reg      <= samp_next;
            conv_pend_reg <= conv_pend_next;
            prod_reg      <= 48'(ch_reg) * 48'(fr_reg);
            if (conv_pend_next)
                mant_reg <= acc_shift;
            if (accept && func == aiff_pkg::FUNC_RESTART)
                rate_reg <= 32'd0;
            else if (conv_pend_reg)
                rate_reg <= conv_rate;
            if (res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (res_valid)
            begin
                kind_reg  <= res_kind;
                word_reg  <= res_word;
                last_reg  <= res_last;
                och_reg   <= res_hdr ? ch_reg : 16'd0;
                ofr_reg   <= res_hdr ? fr_reg : 32'd0;
                odep_reg  <= res_hdr ? dep_reg : 16'd0;
                orate_reg <= res_hdr ? rate_reg : 32'd0;
                ofmt_reg  <= res_hdr ? fmt_reg : aiff_pkg::FMT_UNKNOWN;
                oerr_reg  <= res_err;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign sample_word    = word_reg;
    assign last_sample    = last_reg;
    assign channel_count  = och_reg;
    assign frame_count    = ofr_reg;
    assign bit_depth      = odep_reg;
    assign sample_rate_hz = orate_reg;
    assign sample_format  = ofmt_reg;
    assign error_code     = oerr_reg;

endmodule

// ===== tb/aiff_stream_parser_test.sv =====
// ----------------------------------------------------------------------------
// aiff_stream_parser_test
// Feeds directed and random AIFF/AIFC byte streams to the parser, predicts
// header, sample and error results, and checks each one field by field.
// ----------------------------------------------------------------------------
module aiff_stream_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        P_FORM, P_FSIZE, P_FTYPE, P_CID, P_CSIZE, P_SKIP, P_CH, P_FR, P_BD,
        P_EXP, P_MANT, P_CTYPE, P_SOFF, P_SBLK, P_SSKIP, P_SAMP, P_DONE, P_HALT
    } phase_t;

    typedef struct packed {
        logic        hold_off;
        logic [1:0]  fn;
        logic [7:0]  b;
    } word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] sample_word;
        logic        last_sample;
        logic [15:0] channel_count;
        logic [31:0] frame_count;
        logic [15:0] bit_depth;
        logic [31:0] sample_rate_hz;
        logic [2:0]  sample_format;
        logic [2:0]  error_code;
    } result_t;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [31:0] TAG_JUNK = 32'h4A554E4B;
    localparam int TIMEOUT_CYCLES = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = '0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [63:0] sample_word;
    logic        last_sample;
    logic [15:0] channel_count;
    logic [31:0] frame_count;
    logic [15:0] bit_depth;
    logic signed [31:0] sample_rate_hz;
    logic [2:0]  sample_format;
    logic [2:0]  error_code;

    aiff_stream_parser u_top (.*);

    always #6 clk = ~clk;

    word_t   pending_words[$];
    word_t   file_words[$];
    result_t expected_results[$];
    int      accepted_words = 0;
    int      total_words = 0;
    int      mismatches = 0;
    int      cycles = 0;

    phase_t      ph;
    int          fidx;
    logic [63:0] facc;
    logic [31:0] ctag;
    logic [32:0] skip_left;
    logic        compressed;
    logic        have_comm;
    logic [15:0] chans;
    logic [31:0] frames;
    logic [15:0] depth;
    logic [2:0]  fmt;
    logic [15:0] rate_exp;
    logic [31:0] rate;
    logic [47:0] samples_left;

    function automatic logic [31:0] rate_from_ext(logic [15:0] se, logic [63:0] mant);
        int          shift;
        logic [63:0] mag;
        logic [63:0] cap;
        cap = 64'h8000_0000;
        shift = int'(se[14:0]) - aiff_pkg::EXT_BIAS - aiff_pkg::MANT_POINT;
        if (mant == 0)
        begin
            return 32'd0;
        end
        if (shift >= 0)
        begin
            if (shift >= 32 || mant > (cap >> shift))
                mag = cap;
            else
                mag = mant << shift;
        end
        else
        begin
            mag = (-shift >= 64) ? 64'd0 : (mant >> (-shift));
            if (mag > cap)
                mag = cap;
        end
        if (se[15])
            return 32'd0 - mag[31:0];
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    task automatic clear_parser();
        ph = P_FORM;
        fidx = 0;
        facc = '0;
        ctag = '0;
        skip_left = '0;
        compressed = 1'b0;
        have_comm = 1'b0;
        chans = '0;
        frames = '0;
        depth = '0;
        fmt = aiff_pkg::FMT_UNKNOWN;
        rate_exp = '0;
        rate = '0;
        samples_left = '0;
    endtask

    task automatic expect_error(logic [2:0] code);
        result_t r;
        r = '0;
        r.kind = aiff_pkg::KIND_ERROR;
        r.error_code = code;
        expected_results.push_back(r);
        ph = P_HALT;
    endtask

    task automatic expect_header();
        result_t r;
        samples_left = 48'(chans) * 48'(frames);
        r = '0;
        r.kind = aiff_pkg::KIND_HEADER;
        r.channel_count = chans;
        r.frame_count = frames;
        r.bit_depth = depth;
        r.sample_rate_hz = rate;
        r.sample_format = fmt;
        expected_results.push_back(r);
        ph = (samples_left == 0) ? P_DONE : P_SAMP;
    endtask

    task automatic close_comm(logic [31:0] ctype);
        logic [2:0] f;
        f = aiff_pkg::FMT_UNKNOWN;
        if (compressed && ctype == aiff_pkg::TAG_FL32)
        begin
            f = aiff_pkg::FMT_F32;
            depth = 16'd32;
        end
        else if (compressed && ctype == aiff_pkg::TAG_FL64)
        begin
            f = aiff_pkg::FMT_F64;
            depth = 16'd64;
        end
        if (f == aiff_pkg::FMT_UNKNOWN)
        begin
            case (depth)
                16'd8:  f = aiff_pkg::FMT_S8;
                16'd16: f = aiff_pkg::FMT_S16;
                16'd24: f = aiff_pkg::FMT_S24;
                16'd32: f = aiff_pkg::FMT_S32;
                16'd64: f = aiff_pkg::FMT_F64;
                default: f = aiff_pkg::FMT_UNKNOWN;
            endcase
        end
        fmt = f;
        if (f == aiff_pkg::FMT_UNKNOWN)
        begin
            expect_error(aiff_pkg::ERR_DEPTH);
        end
        else
        begin
            have_comm = 1'b1;
            ph = (skip_left == 0) ? P_CID : P_SKIP;
        end
    endtask

    task automatic parse_word(logic [1:0] fn, logic [7:0] b);
        int          len;
        logic [63:0] v;
        logic [32:0] sz;
        logic [32:0] need;
        result_t     r;
        if (fn == aiff_pkg::FUNC_RESTART)
        begin
            clear_parser();
            return;
        end
        if (fn == FUNC_UNUSED || ph == P_DONE || ph == P_HALT)
            return;
        if (fn == aiff_pkg::FUNC_EOS)
        begin
            if (ph == P_FORM)
                expect_error(aiff_pkg::ERR_NO_FORM);
            else if (ph <= P_FTYPE)
                expect_error(aiff_pkg::ERR_FORM_TYPE);
            else if (ph <= P_CTYPE)
                expect_error(aiff_pkg::ERR_MISSING);
            else
                expect_error(aiff_pkg::ERR_SHORT);
            return;
        end
        if (ph == P_SKIP)
        begin
            skip_left--;
            if (skip_left == 0)
                ph = P_CID;
            return;
        end
        if (ph == P_SSKIP)
        begin
            skip_left--;
            if (skip_left == 0)
                expect_header();
            return;
        end
        case (ph)
            P_CH, P_BD, P_EXP: len = 2;
            P_MANT:            len = 8;
            P_SAMP:            len = int'(depth >> 3);
            default:           len = 4;
        endcase
        if (len == 0 || len > 8)
            len = 1;
        facc = {facc[55:0], b};
        fidx++;
        if (fidx < len)
            return;
        v = facc;
        facc = '0;
        fidx = 0;
        case (ph)
            P_FORM:
                if (v[31:0] != aiff_pkg::TAG_FORM)
                    expect_error(aiff_pkg::ERR_NO_FORM);
                else
                    ph = P_FSIZE;
            P_FSIZE: ph = P_FTYPE;
            P_FTYPE:
                if (v[31:0] == aiff_pkg::TAG_AIFF || v[31:0] == aiff_pkg::TAG_AIFC)
                begin
                    compressed = (v[31:0] == aiff_pkg::TAG_AIFC);
                    ph = P_CID;
                end
                else
                begin
                    expect_error(aiff_pkg::ERR_FORM_TYPE);
                end
            P_CID:
            begin
                ctag = v[31:0];
                ph = P_CSIZE;
            end
            P_CSIZE:
            begin
                sz = {1'b0, v[31:0]};
                if (ctag == aiff_pkg::TAG_COMM)
                begin
                    need = compressed ? 33'd22 : 33'd18;
                    if (sz < need)
                    begin
                        expect_error(aiff_pkg::ERR_SHORT);
                    end
                    else
                    begin
                        skip_left = sz + sz[0] - need;
                        ph = P_CH;
                    end
                end
                else if (ctag == aiff_pkg::TAG_SSND)
                begin
                    if (!have_comm)
                        expect_error(aiff_pkg::ERR_SSND_FIRST);
                    else if (sz < 33'd8)
                        expect_error(aiff_pkg::ERR_SHORT);
                    else
                        ph = P_SOFF;
                end
                else
                begin
                    skip_left = sz + sz[0];
                    ph = (skip_left == 0) ? P_CID : P_SKIP;
                end
            end
            P_CH:
            begin
                chans = v[15:0];
                ph = P_FR;
            end
            P_FR:
            begin
                frames = v[31:0];
                ph = P_BD;
            end
            P_BD:
            begin
                depth = v[15:0];
                ph = P_EXP;
            end
            P_EXP:
            begin
                rate_exp = v[15:0];
                ph = P_MANT;
            end
            P_MANT:
            begin
                rate = rate_from_ext(rate_exp, v);
                if (compressed)
                    ph = P_CTYPE;
                else
                    close_comm(32'd0);
            end
            P_CTYPE: close_comm(v[31:0]);
            P_SOFF:
            begin
                skip_left = {1'b0, v[31:0]};
                ph = P_SBLK;
            end
            P_SBLK:
                if (skip_left == 0)
                    expect_header();
                else
                    ph = P_SSKIP;
            P_SAMP:
            begin
                samples_left--;
                r = '0;
                r.kind = aiff_pkg::KIND_SAMPLE;
                r.sample_word = v;
                r.last_sample = (samples_left == 0);
                expected_results.push_back(r);
                if (samples_left == 0)
                    ph = P_DONE;
            end
            default: ;
        endcase
    endtask

    task automatic put_word(logic [1:0] fn, logic [7:0] b);
        file_words.push_back('{hold_off: 1'b0, fn: fn, b: b});
    endtask

    task automatic put_u32(logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            put_word(aiff_pkg::FUNC_DATA, v[i*8 +: 8]);
    endtask

    task automatic put_fill(int n);
        for (int i = 0; i < n; i++)
            put_word(aiff_pkg::FUNC_DATA, 8'($urandom));
    endtask

    // order: 0 normal, 1 SSND before COMM, 2 COMM twice, 3 short SSND
    task automatic add_file(logic aifc, logic [31:0] ftag, logic [31:0] ctype,
                            logic [15:0] ch, logic [31:0] fr, logic [15:0] bd,
                            logic [15:0] ex, logic [63:0] mant, int off,
                            int comm_extra, int junk, int order, int cut);
        int n_samp;
        int bps;
        int csize;
        file_words.delete();
        put_word(aiff_pkg::FUNC_RESTART, 8'($urandom));
        put_u32(ftag);
        put_u32($urandom);
        put_u32(aifc ? aiff_pkg::TAG_AIFC : aiff_pkg::TAG_AIFF);
        if (junk >= 0)
        begin
            put_u32(TAG_JUNK);
            put_u32(junk);
            put_fill(junk + junk % 2);
        end
        if (order == 1)
        begin
            put_u32(aiff_pkg::TAG_SSND);
            put_u32(32'd8);
        end
        for (int k = 0; k < ((order == 2) ? 2 : 1); k++)
        begin
            csize = (aifc ? 22 : 18) + comm_extra;
            put_u32(aiff_pkg::TAG_COMM);
            put_u32(csize);
            if (k == 0 && order == 2)
                put_word(aiff_pkg::FUNC_DATA, 8'd0);
            put_word(aiff_pkg::FUNC_DATA, ch[15:8]);
            put_word(aiff_pkg::FUNC_DATA, ch[7:0]);
            put_u32(fr);
            put_word(aiff_pkg::FUNC_DATA, bd[15:8]);
            put_word(aiff_pkg::FUNC_DATA, bd[7:0]);
            put_word(aiff_pkg::FUNC_DATA, ex[15:8]);
            put_word(aiff_pkg::FUNC_DATA, ex[7:0]);
            put_u32(mant[63:32]);
            put_u32(mant[31:0]);
            if (aifc)
                put_u32(ctype);
            if (comm_extra > 0)
                put_fill(comm_extra + csize % 2);
        end
        bps = int'(bd) / 8;
        if (aifc && ctype == aiff_pkg::TAG_FL32)
            bps = 4;
        if (aifc && ctype == aiff_pkg::TAG_FL64)
            bps = 8;
        if (bps == 0 || bps > 8)
            bps = 1;
        n_samp = int'(ch) * int'(fr);
        if (fr > 64 || n_samp > 64)
            n_samp = 0;
        put_u32(aiff_pkg::TAG_SSND);
        put_u32((order == 3) ? 32'd4 : 32'(8 + off + n_samp * bps));
        put_u32(off);
        put_u32($urandom);
        put_fill(off + n_samp * bps);
        put_fill($urandom_range(2));
        if (cut >= 0 && cut < file_words.size())
            file_words = file_words[0:cut-1];
        put_word(aiff_pkg::FUNC_EOS, 8'($urandom));
        foreach (file_words[i])
            pending_words.push_back(file_words[i]);
    endtask

    function automatic logic [15:0] pick_depth();
        case ($urandom_range(7))
            0: return 16'd8;
            1: return 16'd16;
            2: return 16'd24;
            3: return 16'd32;
            4: return 16'd64;
            5: return 16'($urandom);
            default: return 16'd16;
        endcase
    endfunction

    function automatic logic [31:0] pick_ctype();
        case ($urandom_range(3))
            0: return aiff_pkg::TAG_FL32;
            1: return aiff_pkg::TAG_FL64;
            2: return 32'h4E4F4E45;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_file();
        logic [15:0] ex;
        logic [63:0] mant;
        int          cut;
        ex = ($urandom_range(3) == 0) ? 16'($urandom)
             : {1'($urandom), 15'(aiff_pkg::EXP_UNITY - 63 + $urandom_range(100))};
        mant = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            mant = '0;
        cut = ($urandom_range(4) == 0) ? $urandom_range(90) : -1;
        add_file(1'($urandom),
                 ($urandom_range(15) == 0) ? $urandom : aiff_pkg::TAG_FORM,
                 pick_ctype(), 16'($urandom_range(3)), $urandom_range(4),
                 pick_depth(), ex, mant, $urandom_range(3),
                 ($urandom_range(5) == 0) ? $urandom_range(5) - 2 : 0,
                 ($urandom_range(2) == 0) ? $urandom_range(5) : -1,
                 ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0, cut);
    endtask

    task automatic add_noise(int n);
        for (int i = 0; i < n; i++)
            pending_words.push_back('{hold_off: 1'b0, fn: 2'($urandom),
                                       b: 8'($urandom)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= aiff_pkg::FUNC_DATA;
            data_byte <= '0;
        end
        else
        begin
            int   pct;
            logic send;
            if (in_valid && in_ready)
            begin
                parse_word(func, data_byte);
                accepted_words++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_words.size() > 0 && pending_words[0].hold_off
                    && expected_results.size() == 0)
                    void'(pending_words.pop_front());
                pct = (accepted_words < total_words / 3) ? 37
                      : (accepted_words < 2 * total_words / 3) ? 88 : 0;
                send = pending_words.size() > 0 && !pending_words[0].hold_off
                       && $urandom_range(99) >= pct;
                if (send)
                begin
                    func <= pending_words[0].fn;
                    data_byte <= pending_words[0].b;
                    void'(pending_words.pop_front());
                end
                in_valid <= send;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            int      pct;
            result_t got;
            result_t want;
            cycles++;
            if (out_valid && out_ready)
            begin
                got = '{kind, sample_word, last_sample, channel_count, frame_count,
                        bit_depth, sample_rate_hz, sample_format, error_code};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind || got.sample_word != want.sample_word
                        || got.last_sample != want.last_sample
                        || got.channel_count != want.channel_count
                        || got.frame_count != want.frame_count
                        || got.bit_depth != want.bit_depth
                        || got.sample_rate_hz != want.sample_rate_hz
                        || got.sample_format != want.sample_format
                        || got.error_code != want.error_code)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            pct = (accepted_words < total_words / 3) ? 88
                  : (accepted_words < 2 * total_words / 3) ? 37 : 0;
            out_ready <= ($urandom_range(99) >= pct);
        end
    end

    always @(negedge clk)
    begin
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        // directed files
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd2, 32'd3, 16'd16, 16'h400E,
                 64'hAC44 << 48, 0, 0, 3, 0, -1);
        add_file(1, aiff_pkg::TAG_FORM, aiff_pkg::TAG_FL32, 16'd1, 32'd2, 16'd8,
                 16'hC01E, 64'hFFFF_FFFF_FFFF_FFFF, 2, 2, -1, 0, -1);
        add_file(1, aiff_pkg::TAG_FORM, aiff_pkg::TAG_FL64, 16'd1, 32'd2, 16'd16,
                 16'h7FFF, 64'h1, 0, 1, 0, 0, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd3, 16'd24, 16'hFFFF,
                 64'h8000_0000_0000_0000, 1, 0, -1, 0, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd3, 32'd1, 16'd32, 16'h0000, 64'h0,
                 0, 0, -1, 0, -1);
        add_file(1, aiff_pkg::TAG_FORM, 32'h4E4F4E45, 16'd1, 32'd1, 16'd64, 16'h401D,
                 64'hFFFF_FFFF_0000_0000, 0, 0, -1, 0, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'hFFFF, 32'd0, 16'd8, 16'h401E,
                 64'h8000_0000_0000_0000, 0, 0, -1, 0, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd0, 32'hFFFF_FFFF, 16'd8, 16'hC01E,
                 64'h8000_0000_0000_0000, 0, 0, -1, 0, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd12, 16'h400E, 64'h1,
                 0, 0, -1, 0, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, -1, -1, 0, -1);
        add_file(1, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, -3, -1, 0, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, 0, -1, 1, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, 0, -1, 2, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, 0, -1, 3, -1);
        add_file(0, 32'h464F5258, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, 0, -1, 0, -1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, 0, -1, 0, 1);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, 0, -1, 0, 7);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd1, 16'd8, 16'h400E, 64'h1,
                 0, 0, -1, 0, 20);
        add_file(0, aiff_pkg::TAG_FORM, 0, 16'd1, 32'd2, 16'd8, 16'h400E, 64'h1,
                 2, 0, -1, 0, 50);
        pending_words.push_back('{hold_off: 1'b0, fn: FUNC_UNUSED, b: 8'hFF});
        pending_words.push_back('{hold_off: 1'b1, fn: aiff_pkg::FUNC_DATA, b: 8'h00});
        while (pending_words.size() < 2000)
        begin
            if ($urandom_range(9) == 0)
                add_noise($urandom_range(1, 20));
            else
                add_random_file();
            if (pending_words.size() > 1000 && pending_words.size() < 1100)
                pending_words.push_back('{hold_off: 1'b1, fn: aiff_pkg::FUNC_DATA,
                                          b: 8'h00});
        end
        total_words = pending_words.size();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
